@@ rtl/stc_pkg.sv @@
// Package for the symbol transition counter: sizes, symbol constants, the
// command type shared by the front end, queue and back end, and the entry and
// result types of the back end. Depends on nothing.
`default_nettype none

package stc_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int COUNT_WIDTH   = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SYM_ZERO      = 8'h00;
    localparam logic [7:0] SYM_SPACE     = 8'h20;
    localparam logic [7:0] IGNORED_RESET = 8'd78;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // What the back end has to do for one request.
    typedef enum logic [1:0] {
        K_ZERO,
        K_READ,
        K_PAIR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  from_sym;
        logic [7:0]  to_sym;
        logic [5:0]  entry_index;
    } t_cmd;

    typedef struct packed {
        logic [7:0]             from_sym;
        logic [7:0]             to_sym;
        logic [COUNT_WIDTH-1:0] tally;
    } t_entry;

    typedef struct packed {
        logic        counted;
        logic [5:0]  slot;
        logic [31:0] pair_count;
        logic        new_pair;
        logic        table_full;
        logic [7:0]  from_symbol;
        logic [7:0]  to_symbol;
        logic        entry_used;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH
    } t_back_state;

endpackage

`default_nettype wire

@@ rtl/stc_if.sv @@
// Valid/ready channel interfaces for the request and result streams.
// Depends on nothing.
`default_nettype none

interface stc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] symbol;
    logic [5:0] entry_index;

    modport source (output valid, action, symbol, entry_index, input ready);
    modport sink   (input valid, action, symbol, entry_index, output ready);
endinterface

interface stc_out_if;
    logic        valid;
    logic        ready;
    logic        counted;
    logic [5:0]  slot;
    logic [31:0] pair_count;
    logic        new_pair;
    logic        table_full;
    logic [7:0]  from_symbol;
    logic [7:0]  to_symbol;
    logic        entry_used;

    modport source (output valid, counted, slot, pair_count, new_pair, table_full,
                    from_symbol, to_symbol, entry_used, input ready);
    modport sink   (input valid, counted, slot, pair_count, new_pair, table_full,
                    from_symbol, to_symbol, entry_used, output ready);
endinterface

`default_nettype wire

@@ rtl/stc_front.sv @@
// Front end: accepts requests, holds the ignored-symbol register and the
// previous symbol, and turns each request into a command. Uses stc_pkg, stc_if.
`default_nettype none

module stc_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    stc_in_if.sink           i_in,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_q_ready,
    output logic             o_push,
    output stc_pkg::t_cmd    o_cmd
);

    logic [7:0] r_ignored;
    logic [7:0] r_prev;
    logic       r_have_prev;
    logic [7:0] n_prev;
    logic       n_have_prev;
    logic       skip;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    always_comb begin
        skip = (i_in.symbol == stc_pkg::SYM_ZERO) || (i_in.symbol == stc_pkg::SYM_SPACE)
            || (i_in.symbol == r_ignored);
        n_prev            = r_prev;
        n_have_prev       = r_have_prev;
        o_cmd.kind        = stc_pkg::K_ZERO;
        o_cmd.from_sym    = r_prev;
        o_cmd.to_sym      = i_in.symbol;
        o_cmd.entry_index = i_in.entry_index;
        if (i_in.action) begin
            o_cmd.kind = stc_pkg::K_READ;
        end else if (!skip) begin
            n_prev      = i_in.symbol;
            n_have_prev = 1'b1;
            // The very first symbol only primes the previous symbol.
            if (r_have_prev) begin
                o_cmd.kind = stc_pkg::K_PAIR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignored   <= stc_pkg::IGNORED_RESET;
            r_prev      <= stc_pkg::SYM_ZERO;
            r_have_prev <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ignored <= i_cfg_wr_data;
            end
            if (o_push) begin
                r_prev      <= n_prev;
                r_have_prev <= n_have_prev;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/stc_queue.sv @@
// Short command queue between the front end and the back end.
// Uses stc_pkg.
`default_nettype none

module stc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire stc_pkg::t_cmd  i_cmd,
    output logic                o_ready,
    output logic                o_valid,
    output stc_pkg::t_cmd       o_cmd,
    input  wire logic           i_pop
);

    stc_pkg::t_cmd                r_mem [stc_pkg::QUEUE_DEPTH];
    logic [stc_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [stc_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [stc_pkg::QCNT_W-1:0]   r_count;

    localparam logic [stc_pkg::QPTR_W-1:0] LAST = stc_pkg::QPTR_W'(stc_pkg::QUEUE_DEPTH - 1);

    assign o_ready = (r_count != stc_pkg::QCNT_W'(stc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/stc_back.sv @@
// Back end: owns the transition table memory and the fill count, searches the
// table one entry per cycle and drives the result register. Uses stc_pkg, stc_if.
`default_nettype none

module stc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire stc_pkg::t_cmd  i_cmd,
    output logic                o_pop,
    stc_out_if.source           o_out
);

    stc_pkg::t_entry               r_mem [stc_pkg::TABLE_ENTRIES];
    stc_pkg::t_entry               r_rdata;
    stc_pkg::t_back_state          r_state, n_state;
    logic [stc_pkg::FILL_W-1:0]    r_filled, n_filled;
    logic [stc_pkg::IDX_W-1:0]     r_ptr, n_ptr;
    stc_pkg::t_cmd                 r_cmd;
    logic                          r_out_valid;
    stc_pkg::t_result              r_res, n_res;
    logic                          ld;
    logic                          rd_en;
    logic [stc_pkg::IDX_W-1:0]     rd_addr;
    logic                          wr_en;
    logic [stc_pkg::IDX_W-1:0]     wr_addr;
    stc_pkg::t_entry               wr_data;
    logic                          hit;
    logic [stc_pkg::FILL_W-1:0]    ptr_next;

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_filled = r_filled;
        n_ptr    = r_ptr;
        n_res    = '0;
        ld       = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_ptr;
        wr_en    = 1'b0;
        wr_addr  = r_ptr;
        wr_data  = r_rdata;
        o_pop    = 1'b0;
        hit      = (stc_pkg::FILL_W'(r_ptr) < r_filled)
                && (r_rdata.from_sym == r_cmd.from_sym) && (r_rdata.to_sym == r_cmd.to_sym);
        ptr_next = stc_pkg::FILL_W'(r_ptr) + stc_pkg::FILL_W'(1);

        unique case (r_state)
            stc_pkg::S_IDLE: begin
                // Only take a command when the result register can hold its answer.
                if (i_q_valid && (!r_out_valid || o_out.ready)) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        stc_pkg::K_ZERO: begin
                            ld = 1'b1;
                        end
                        stc_pkg::K_READ: begin
                            if (32'(i_cmd.entry_index) < 32'(r_filled)) begin
                                rd_en   = 1'b1;
                                rd_addr = stc_pkg::IDX_W'(i_cmd.entry_index);
                                n_state = stc_pkg::S_READ;
                            end else begin
                                ld         = 1'b1;
                                n_res.slot = i_cmd.entry_index;
                            end
                        end
                        stc_pkg::K_PAIR: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_ptr   = '0;
                            n_state = stc_pkg::S_SEARCH;
                        end
                        default: begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            stc_pkg::S_READ: begin
                ld                = 1'b1;
                n_res.slot        = r_cmd.entry_index;
                n_res.pair_count  = 32'(r_rdata.tally);
                n_res.from_symbol = r_rdata.from_sym;
                n_res.to_symbol   = r_rdata.to_sym;
                n_res.entry_used  = 1'b1;
                n_state           = stc_pkg::S_IDLE;
            end
            stc_pkg::S_SEARCH: begin
                n_res.from_symbol = r_cmd.from_sym;
                n_res.to_symbol   = r_cmd.to_sym;
                if (hit) begin
                    wr_en         = 1'b1;
                    wr_addr       = r_ptr;
                    wr_data.tally = (r_rdata.tally == stc_pkg::COUNT_MAX)
                                  ? r_rdata.tally : r_rdata.tally + 1'b1;
                    ld               = 1'b1;
                    n_res.counted    = 1'b1;
                    n_res.slot       = 6'(r_ptr);
                    n_res.pair_count = 32'(wr_data.tally);
                    n_res.entry_used = 1'b1;
                    n_state          = stc_pkg::S_IDLE;
                end else if (ptr_next < r_filled) begin
                    rd_en   = 1'b1;
                    rd_addr = stc_pkg::IDX_W'(ptr_next);
                    n_ptr   = stc_pkg::IDX_W'(ptr_next);
                end else if (r_filled == stc_pkg::FILL_W'(stc_pkg::TABLE_ENTRIES)) begin
                    ld               = 1'b1;
                    n_res.table_full = 1'b1;
                    n_state          = stc_pkg::S_IDLE;
                end else begin
                    wr_en            = 1'b1;
                    wr_addr          = stc_pkg::IDX_W'(r_filled);
                    wr_data.from_sym = r_cmd.from_sym;
                    wr_data.to_sym   = r_cmd.to_sym;
                    wr_data.tally    = stc_pkg::COUNT_WIDTH'(1);
                    n_filled         = r_filled + 1'b1;
                    ld               = 1'b1;
                    n_res.counted    = 1'b1;
                    n_res.slot       = 6'(r_filled);
                    n_res.pair_count = 32'(1);
                    n_res.new_pair   = 1'b1;
                    n_res.entry_used = 1'b1;
                    n_state          = stc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stc_pkg::S_IDLE;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (ld) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.counted     = r_res.counted;
    assign o_out.slot        = r_res.slot;
    assign o_out.pair_count  = r_res.pair_count;
    assign o_out.new_pair    = r_res.new_pair;
    assign o_out.table_full  = r_res.table_full;
    assign o_out.from_symbol = r_res.from_symbol;
    assign o_out.to_symbol   = r_res.to_symbol;
    assign o_out.entry_used  = r_res.entry_used;

endmodule

`default_nettype wire

@@ rtl/symbol_transition_counter_core.sv @@
// A skipped or first symbol loads its answer when its request leaves the queue, an
// in-range entry read answers after the registered memory read, and a symbol pair
// searches N entries, at least 1 and up to 64; the table search reads one memory entry per cycle.
// Throughput is one request per back-end pass; the two-deep queue lets requests arrive
// while a search runs. Reset empties the table, clears the previous symbol and loads
// 78 into the ignored-symbol register; no clearing pass is needed.
`default_nettype none

module symbol_transition_counter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    stc_in_if.sink           i_in,
    stc_out_if.source        o_out,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data
);

    // The front end classifies each request as soon as it is taken: reads of the table,
    // symbols that are skipped or only prime the previous symbol, and real symbol pairs.
    // Only the previous symbol and the ignored-symbol register live in the front end,
    // so it can run ahead of the table search by as many requests as the queue holds.
    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;
    stc_pkg::t_cmd  push_cmd;
    stc_pkg::t_cmd  pop_cmd;

    stc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    stc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd),
        .i_pop   (pop)
    );

    // For a pair, the back end walks the filled entries in fill order, updates a
    // matching entry with a saturating count, appends the pair at the fill count
    // or reports a full table. Its result register lets the back end start the
    // next command while the previous result is being taken.
    stc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (pop_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
